FILE: hdl/sirt_pkg.sv
// Shared constants, types and helper functions for the signed integer to radix text block.
package sirt_pkg;

    localparam int unsigned VALUE_W      = 32;
    localparam int unsigned CHAR_W       = 8;
    localparam int unsigned BASE_W       = 5;
    localparam int unsigned ALPHA_W      = 64;
    localparam int unsigned CFG_IDX_W    = 2;
    localparam int unsigned DIGIT_W      = 4;
    localparam int unsigned MAX_DIGITS   = 32;
    localparam int unsigned DIGIT_IDX_W  = $clog2(MAX_DIGITS);
    localparam int unsigned COUNT_W      = DIGIT_IDX_W + 1;
    localparam int unsigned REG_SYMBOLS  = 16;
    localparam int unsigned MAX_SYMBOLS  = 16;
    localparam int unsigned SYMBOL_LIMIT =
        (MAX_SYMBOLS > REG_SYMBOLS) ? REG_SYMBOLS : MAX_SYMBOLS;
    localparam int unsigned QUEUE_DEPTH  = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BASE_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_HIGH = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    localparam logic [BASE_W-1:0]  RST_BASE_SIZE  = 5'd10;
    localparam logic [ALPHA_W-1:0] RST_ALPHA_LOW  = 64'h3736_3534_3332_3130;
    localparam logic [ALPHA_W-1:0] RST_ALPHA_HIGH = 64'h0000_0000_0000_3938;

    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } t_item;

    // Symbol character for a digit index, taken from the two alphabet registers.
    function automatic logic [CHAR_W-1:0] symbol_at(input logic [ALPHA_W-1:0] lo,
                                                    input logic [ALPHA_W-1:0] hi,
                                                    input logic [DIGIT_W-1:0] idx);
        logic [2*ALPHA_W-1:0] all_sym;
        all_sym = {hi, lo};
        return all_sym[CHAR_W*idx +: CHAR_W];
    endfunction

endpackage

FILE: hdl/sirt_if.sv
// Channel interfaces: input value beats, output character beats and configuration writes.
interface sirt_value_if;
    import sirt_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sirt_char_if;
    import sirt_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] text_char;
    logic              last_char;
    modport source (output valid, output text_char, output last_char, input ready);
    modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

interface sirt_cfg_if;
    import sirt_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [ALPHA_W-1:0]   data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/signed_integer_to_radix_text.sv
// An accepted value is stored in the queue and reaches the engine once the engine is idle;
// each digit takes one pass per significant byte of the running quotient (1 to 4), then the
// sign, if any, and the digits leave one character per cycle while o_text.ready is high.
// The engine holds one value at a time and takes the next after loading the last character.
// Reset (synchronous, active low) restores radix ten with digits 0 to 9 and empties the queue.
// Beats taken while the alphabet is invalid produce no characters.
module signed_integer_to_radix_text #(
    parameter int unsigned QUEUE_DEPTH = sirt_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sirt_value_if.sink  i_value,
    sirt_cfg_if.sink    i_cfg,
    sirt_char_if.source o_text
);
    import sirt_pkg::*;

    // Configuration registers. Writes must be issued only while the block is idle, so the engine
    // sees a stable radix and alphabet for a whole conversion; the block does not enforce this.
    logic [BASE_W-1:0]  r_base_size;
    logic [ALPHA_W-1:0] r_alpha_low;
    logic [ALPHA_W-1:0] r_alpha_high;

    // Handshake between front end, queue and engine.
    logic  push;
    logic  pop;
    logic  queue_full;
    logic  queue_empty;
    t_item front_item;
    t_item queue_item;

    // The configuration channel never stalls; writes to an unknown index
    // are accepted and ignored.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_size  <= RST_BASE_SIZE;
            r_alpha_low  <= RST_ALPHA_LOW;
            r_alpha_high <= RST_ALPHA_HIGH;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_BASE_SIZE:  r_base_size  <= i_cfg.data[BASE_W-1:0];
                REG_ALPHA_LOW:  r_alpha_low  <= i_cfg.data;
                REG_ALPHA_HIGH: r_alpha_high <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // The front end takes a beat whenever the queue has room, checks the
    // alphabet and turns the signed value into sign plus magnitude.
    sirt_front u_front (
        .i_value      (i_value),
        .i_base_size  (r_base_size),
        .i_alpha_low  (r_alpha_low),
        .i_alpha_high (r_alpha_high),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_item       (front_item)
    );

    sirt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_empty (queue_empty),
        .o_item  (queue_item)
    );

    // The engine stores digits least significant first, then plays them
    // back most significant first through a registered output stage.
    sirt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_radix      (r_base_size),
        .i_alpha_low  (r_alpha_low),
        .i_alpha_high (r_alpha_high),
        .i_empty      (queue_empty),
        .i_item       (queue_item),
        .o_pop        (pop),
        .o_text       (o_text)
    );

endmodule

FILE: hdl/sirt_front.sv
// Front end: accepts values, checks the alphabet and forms sign and magnitude for the queue.
module sirt_front (
    sirt_value_if.sink                  i_value,
    input  logic [sirt_pkg::BASE_W-1:0]  i_base_size,
    input  logic [sirt_pkg::ALPHA_W-1:0] i_alpha_low,
    input  logic [sirt_pkg::ALPHA_W-1:0] i_alpha_high,
    input  logic                         i_queue_full,
    output logic                         o_push,
    output sirt_pkg::t_item              o_item
);
    import sirt_pkg::*;

    localparam logic [BASE_W-1:0] LIMIT = BASE_W'(SYMBOL_LIMIT);

    logic               alpha_ok;
    logic [VALUE_W-1:0] value_u;

    // The alphabet is usable when it has enough symbols, no sign characters
    // and no symbol appears twice among the ones in use.
    always_comb begin
        alpha_ok = (i_base_size >= BASE_W'(2)) && (i_base_size <= LIMIT);
        for (int i = 0; i < REG_SYMBOLS; i++) begin
            if (BASE_W'(i) < i_base_size) begin
                if (symbol_at(i_alpha_low, i_alpha_high, DIGIT_W'(i)) == CHAR_PLUS ||
                    symbol_at(i_alpha_low, i_alpha_high, DIGIT_W'(i)) == CHAR_MINUS) begin
                    alpha_ok = 1'b0;
                end
                for (int j = i + 1; j < REG_SYMBOLS; j++) begin
                    if (BASE_W'(j) < i_base_size &&
                        symbol_at(i_alpha_low, i_alpha_high, DIGIT_W'(j)) ==
                        symbol_at(i_alpha_low, i_alpha_high, DIGIT_W'(i))) begin
                        alpha_ok = 1'b0;
                    end
                end
            end
        end
    end

    assign value_u       = i_value.value;
    assign i_value.ready = !i_queue_full;
    // Values that arrive while the alphabet is invalid are taken and dropped.
    assign o_push        = i_value.valid && !i_queue_full && alpha_ok;
    assign o_item.neg    = value_u[VALUE_W-1];
    assign o_item.mag    = value_u[VALUE_W-1] ? (~value_u + VALUE_W'(1)) : value_u;

endmodule

FILE: hdl/sirt_queue.sv
// Short queue of classified items between the front end and the conversion engine.
module sirt_queue #(
    parameter int unsigned DEPTH = sirt_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sirt_pkg::t_item i_item,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output sirt_pkg::t_item o_item
);
    import sirt_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

FILE: hdl/sirt_back.sv
// Conversion engine: divides the magnitude by the radix byte by byte and emits the characters.
module sirt_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [sirt_pkg::BASE_W-1:0]  i_radix,
    input  logic [sirt_pkg::ALPHA_W-1:0] i_alpha_low,
    input  logic [sirt_pkg::ALPHA_W-1:0] i_alpha_high,
    input  logic                         i_empty,
    input  sirt_pkg::t_item              i_item,
    output logic                         o_pop,
    sirt_char_if.source                  o_text
);
    import sirt_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_SIGN = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    localparam int unsigned BYTES    = VALUE_W / CHAR_W;
    localparam int unsigned BYTE_W   = $clog2(BYTES);
    localparam logic [COUNT_W-1:0] LAST_CNT = COUNT_W'(MAX_DIGITS - 1);

    logic [1:0]             r_state;
    logic [1:0]             n_state;
    logic                   r_neg;
    logic [VALUE_W-1:0]     r_mag;
    logic [DIGIT_W-1:0]     r_rem;
    logic [BYTE_W-1:0]      r_top;
    logic [BYTE_W-1:0]      r_bidx;
    logic [COUNT_W-1:0]     r_cnt;
    logic [DIGIT_IDX_W-1:0] r_idx;
    logic [DIGIT_W-1:0]     r_digits [MAX_DIGITS];
    logic                   r_ovalid;
    logic [CHAR_W-1:0]      r_ochar;
    logic                   r_olast;

    logic [DIGIT_W-1:0] s_rem;
    logic [DIGIT_W:0]   s_part;
    logic [CHAR_W-1:0]  s_byte;
    logic [CHAR_W-1:0]  s_q;
    logic [VALUE_W-1:0] s_qword;
    logic [BYTE_W-1:0]  s_load_top;
    logic [BYTE_W-1:0]  s_next_top;
    logic               s_div_done;
    logic               out_load;

    // Eight restoring division steps on the current dividend byte.
    always_comb begin
        s_byte = r_mag[CHAR_W*r_bidx +: CHAR_W];
        s_rem  = r_rem;
        s_part = '0;
        s_q    = '0;
        for (int k = CHAR_W - 1; k >= 0; k--) begin
            s_part = {s_rem, s_byte[k]};
            if (s_part >= i_radix) begin
                s_q[k] = 1'b1;
                s_part = s_part - i_radix;
            end
            s_rem = s_part[DIGIT_W-1:0];
        end
        s_qword = r_mag;
        s_qword[CHAR_W*r_bidx +: CHAR_W] = s_q;
    end

    // Highest nonzero byte of a fresh magnitude; later passes drop a byte
    // once the quotient's top byte becomes zero.
    always_comb begin
        s_load_top = '0;
        for (int b = 1; b < BYTES; b++) begin
            if (i_item.mag[CHAR_W*b +: CHAR_W] != '0) begin
                s_load_top = BYTE_W'(b);
            end
        end
        s_next_top = r_top;
        if (r_top != '0 && s_qword[CHAR_W*r_top +: CHAR_W] == '0) begin
            s_next_top = r_top - BYTE_W'(1);
        end
        s_div_done = (s_qword == '0) || (r_cnt == LAST_CNT);
    end

    assign out_load = !r_ovalid || o_text.ready;
    assign o_pop    = (r_state == ST_IDLE) && !i_empty;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (!i_empty) n_state = ST_DIV;
            ST_DIV: begin
                if (r_bidx == '0 && s_div_done) begin
                    n_state = r_neg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: if (out_load) n_state = ST_EMIT;
            ST_EMIT: if (out_load && r_idx == '0) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DIV && r_bidx == '0) begin
            r_digits[r_cnt[DIGIT_IDX_W-1:0]] <= s_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
            r_mag    <= '0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_ovalid <= (r_state == ST_SIGN) || (r_state == ST_EMIT);
            end
            case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_neg  <= i_item.neg;
                        r_mag  <= i_item.mag;
                        r_rem  <= '0;
                        r_top  <= s_load_top;
                        r_bidx <= s_load_top;
                        r_cnt  <= '0;
                    end
                end
                ST_DIV: begin
                    r_mag <= s_qword;
                    if (r_bidx != '0) begin
                        r_rem  <= s_rem;
                        r_bidx <= r_bidx - BYTE_W'(1);
                    end else begin
                        r_cnt  <= r_cnt + COUNT_W'(1);
                        r_rem  <= '0;
                        r_idx  <= r_cnt[DIGIT_IDX_W-1:0];
                        r_top  <= s_next_top;
                        r_bidx <= s_next_top;
                    end
                end
                ST_SIGN: begin
                    if (out_load) begin
                        r_ochar <= CHAR_MINUS;
                        r_olast <= 1'b0;
                    end
                end
                ST_EMIT: begin
                    if (out_load) begin
                        r_ochar <= symbol_at(i_alpha_low, i_alpha_high, r_digits[r_idx]);
                        r_olast <= (r_idx == '0);
                        if (r_idx != '0) begin
                            r_idx <= r_idx - DIGIT_IDX_W'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_text.valid     = r_ovalid;
    assign o_text.text_char = r_ochar;
    assign o_text.last_char = r_olast;

endmodule
